### rtl/core/gsp_pkg.sv
package gsp_pkg;

  // dimension range is 1 .. 2**DIM_BITS-1
  localparam int DIM_BITS   = 16;
  localparam int MAX_DIGITS = 254;
  localparam int CNT_W      = 8;

  // accumulator is wide enough for every legal value plus one saturation code
  localparam int ACC_W = (DIM_BITS + 1 > 17) ? DIM_BITS + 1 : 17;
  localparam logic [ACC_W-1:0] ACC_CAP =
    (DIM_BITS + 1 > 17) ? ACC_W'(64'd1 << DIM_BITS) : ACC_W'(131071);
  localparam logic [ACC_W-1:0] DIM_MAX = ACC_W'((64'd1 << DIM_BITS) - 64'd1);
  localparam logic [ACC_W-1:0] MAXVAL_LIMIT = ACC_W'(65536);
  localparam logic [ACC_W-1:0] ONE_BYTE_MAX = ACC_W'(255);

  localparam logic [7:0] CHAR_P    = 8'h50;
  localparam logic [7:0] CHAR_5    = 8'h35;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_MAGIC     = 3'd0;
  localparam logic [2:0] ERR_NO_WS     = 3'd1;
  localparam logic [2:0] ERR_NO_DIGIT  = 3'd2;
  localparam logic [2:0] ERR_DIGITS    = 3'd3;
  localparam logic [2:0] ERR_MAXVAL    = 3'd4;
  localparam logic [2:0] ERR_DIMENSION = 3'd5;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [16:0] max_value;
    logic        two_byte_pixels;
    logic [15:0] pixel_value;
    logic        last_pixel;
    logic [2:0]  error_code;
  } out_item_t;

  // control from the parser to the number unit
  typedef struct packed {
    logic       load;
    logic       add;
    logic [3:0] digit;
  } num_ctrl_t;

  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic             full;
  } num_stat_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

  function automatic logic dim_ok(input logic [ACC_W-1:0] v);
    return (v != '0) && (v <= DIM_MAX);
  endfunction

endpackage

### rtl/core/gsp_in_if.sv
interface gsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface

### rtl/core/gsp_out_if.sv
interface gsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [16:0] max_value;
  logic        two_byte_pixels;
  logic [15:0] pixel_value;
  logic        last_pixel;
  logic [2:0]  error_code;

  modport source (
    output valid, output result_kind, output image_width, output image_height,
    output max_value, output two_byte_pixels, output pixel_value, output last_pixel,
    output error_code, input ready
  );
  modport sink (
    input valid, input result_kind, input image_width, input image_height,
    input max_value, input two_byte_pixels, input pixel_value, input last_pixel,
    input error_code, output ready
  );
endinterface

### rtl/core/gsp_num.sv
module gsp_num (
  input  logic                clk,
  input  logic                rst,
  input  gsp_pkg::num_ctrl_t  ctrl,
  output gsp_pkg::num_stat_t  stat
);

  logic [gsp_pkg::ACC_W-1:0]   acc;
  logic [gsp_pkg::CNT_W-1:0]   digit_count;
  logic [gsp_pkg::ACC_W+3:0]   prod;
  logic [gsp_pkg::ACC_W-1:0]   acc_sat;

  // acc * 10 + digit as two shifts and adds
  always_comb begin
    prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {(gsp_pkg::ACC_W)'(0), ctrl.digit};
    if (prod > {4'b0, gsp_pkg::ACC_CAP}) begin
      acc_sat = gsp_pkg::ACC_CAP;
    end else begin
      acc_sat = prod[gsp_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      digit_count <= '0;
    end else if (ctrl.load) begin
      acc         <= {(gsp_pkg::ACC_W-4)'(0), ctrl.digit};
      digit_count <= gsp_pkg::CNT_W'(1);
    end else if (ctrl.add) begin
      acc         <= acc_sat;
      digit_count <= digit_count + gsp_pkg::CNT_W'(1);
    end
  end

  assign stat.acc  = acc;
  assign stat.full = (digit_count >= gsp_pkg::CNT_W'(gsp_pkg::MAX_DIGITS));

endmodule

### rtl/core/gsp_fsm.sv
module gsp_fsm (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                start_of_file,
  input  gsp_pkg::num_stat_t  num_stat,
  output gsp_pkg::num_ctrl_t  num_ctrl,
  output logic                res_valid,
  output gsp_pkg::out_item_t  res
);

  localparam logic [3:0] PH_P      = 4'd0;
  localparam logic [3:0] PH_5      = 4'd1;
  localparam logic [3:0] PH_WS     = 4'd2;
  localparam logic [3:0] PH_SKIP_W = 4'd3;
  localparam logic [3:0] PH_DIG_W  = 4'd4;
  localparam logic [3:0] PH_SKIP_H = 4'd5;
  localparam logic [3:0] PH_DIG_H  = 4'd6;
  localparam logic [3:0] PH_SKIP_M = 4'd7;
  localparam logic [3:0] PH_DIG_M  = 4'd8;
  localparam logic [3:0] PH_PIX    = 4'd9;
  localparam logic [3:0] PH_HALT   = 4'd10;

  localparam int AW = gsp_pkg::ACC_W;
  localparam int DW = gsp_pkg::DIM_BITS;

  logic [3:0]    phase, phase_next, cur_phase;
  logic [AW-1:0] held_width, held_width_next;
  logic [AW-1:0] held_height, held_height_next;
  logic          wide, wide_next;
  logic [DW-1:0] column_counter, column_counter_next;
  logic [DW-1:0] row_counter, row_counter_next;
  logic [7:0]    high_byte_hold, high_byte_hold_next;
  logic          byte_phase, byte_phase_next;
  logic          col_last, row_last, is_last;
  logic          err;
  logic [2:0]    err_code;

  assign col_last = ({(AW-DW)'(0), column_counter} + AW'(1)) >= held_width;
  assign row_last = ({(AW-DW)'(0), row_counter} + AW'(1)) >= held_height;
  assign is_last  = col_last && row_last;

  always_comb begin
    // a start marker restarts the parser on this very byte
    cur_phase           = start_of_file ? PH_P : phase;
    phase_next          = cur_phase;
    held_width_next     = held_width;
    held_height_next    = held_height;
    wide_next           = wide;
    column_counter_next = column_counter;
    row_counter_next    = row_counter;
    high_byte_hold_next = high_byte_hold;
    byte_phase_next     = byte_phase;
    num_ctrl.load       = 1'b0;
    num_ctrl.add        = 1'b0;
    num_ctrl.digit      = data_byte[3:0] - gsp_pkg::CHAR_ZERO[3:0];
    res_valid           = 1'b0;
    res                 = '0;
    err                 = 1'b0;
    err_code            = gsp_pkg::ERR_MAGIC;

    case (cur_phase)
      PH_P: begin
        if (data_byte != gsp_pkg::CHAR_P) begin
          err = 1'b1;
        end else begin
          phase_next = PH_5;
        end
      end
      PH_5: begin
        if (data_byte != gsp_pkg::CHAR_5) begin
          err = 1'b1;
        end else begin
          phase_next = PH_WS;
        end
      end
      PH_WS: begin
        if (!gsp_pkg::is_ws(data_byte)) begin
          err      = 1'b1;
          err_code = gsp_pkg::ERR_NO_WS;
        end else begin
          phase_next = PH_SKIP_W;
        end
      end
      PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: begin
        if (!gsp_pkg::is_ws(data_byte)) begin
          if (!gsp_pkg::is_digit(data_byte)) begin
            err      = 1'b1;
            err_code = gsp_pkg::ERR_NO_DIGIT;
          end else begin
            num_ctrl.load = 1'b1;
            phase_next    = cur_phase + 4'd1;
          end
        end
      end
      PH_DIG_W, PH_DIG_H, PH_DIG_M: begin
        if (gsp_pkg::is_digit(data_byte)) begin
          if (num_stat.full) begin
            err      = 1'b1;
            err_code = gsp_pkg::ERR_DIGITS;
          end else begin
            num_ctrl.add = 1'b1;
          end
        end else if (!gsp_pkg::is_ws(data_byte)) begin
          err      = 1'b1;
          err_code = gsp_pkg::ERR_NO_WS;
        end else if (cur_phase == PH_DIG_W) begin
          held_width_next = num_stat.acc;
          phase_next      = PH_SKIP_H;
        end else if (cur_phase == PH_DIG_H) begin
          held_height_next = num_stat.acc;
          phase_next       = PH_SKIP_M;
        end else if ((num_stat.acc == '0) || (num_stat.acc > gsp_pkg::MAXVAL_LIMIT)) begin
          err      = 1'b1;
          err_code = gsp_pkg::ERR_MAXVAL;
        end else if (!gsp_pkg::dim_ok(held_width) || !gsp_pkg::dim_ok(held_height)) begin
          err      = 1'b1;
          err_code = gsp_pkg::ERR_DIMENSION;
        end else begin
          res_valid           = 1'b1;
          res.result_kind     = gsp_pkg::KIND_HEADER;
          res.image_width     = held_width[15:0];
          res.image_height    = held_height[15:0];
          res.max_value       = num_stat.acc[16:0];
          res.two_byte_pixels = num_stat.acc > gsp_pkg::ONE_BYTE_MAX;
          wide_next           = num_stat.acc > gsp_pkg::ONE_BYTE_MAX;
          column_counter_next = '0;
          row_counter_next    = '0;
          byte_phase_next     = 1'b0;
          high_byte_hold_next = '0;
          phase_next          = PH_PIX;
        end
      end
      PH_PIX: begin
        if (wide && !byte_phase) begin
          high_byte_hold_next = data_byte;
          byte_phase_next     = 1'b1;
        end else begin
          byte_phase_next  = 1'b0;
          res_valid        = 1'b1;
          res.result_kind  = gsp_pkg::KIND_PIXEL;
          res.pixel_value  = wide ? {high_byte_hold, data_byte} : {8'd0, data_byte};
          res.last_pixel   = is_last;
          if (is_last) begin
            phase_next = PH_HALT;
          end else if (col_last) begin
            column_counter_next = '0;
            row_counter_next    = row_counter + DW'(1);
          end else begin
            column_counter_next = column_counter + DW'(1);
          end
        end
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase

    if (err) begin
      res_valid      = 1'b1;
      res            = '0;
      res.result_kind = gsp_pkg::KIND_ERROR;
      res.error_code = err_code;
      phase_next     = PH_HALT;
    end

    // the number unit only moves on a byte that is consumed
    if (!step) begin
      num_ctrl.load = 1'b0;
      num_ctrl.add  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_P;
      byte_phase <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      byte_phase <= byte_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      held_width     <= held_width_next;
      held_height    <= held_height_next;
      wide           <= wide_next;
      column_counter <= column_counter_next;
      row_counter    <= row_counter_next;
      high_byte_hold <= high_byte_hold_next;
    end
  end

endmodule

### rtl/core/graymap_stream_parser_top.sv
// Byte-serial parser for binary graymap (P5) files. Each request on in_ch is one file
// byte; start_of_file restarts the parser on that byte. The block checks the magic and
// the header numbers (width, height, maxval), then returns one header result, one pixel
// result per pixel (the final one flagged by last_pixel) and, on any violation, a single
// error result after which bytes are dropped until the next start_of_file. It takes one
// byte per clock while out_ch.ready does not stall it: a byte goes through an input
// register, the combinational parse logic and a result register before its result is
// presented on out_ch. The only stall comes from out_ch.ready; bytes that produce
// no result (magic, digits, whitespace, the high byte of a 16-bit pixel) never wait for
// it once they reach the parse stage with the result register free.
module graymap_stream_parser_top (
  input  logic             clk,
  input  logic             rst,
  gsp_in_if.sink           in_ch,
  gsp_out_if.source        out_ch
);

  logic                s1_valid;
  logic [7:0]          s1_byte;
  logic                s1_sof;
  logic                step;
  logic                out_valid;
  gsp_pkg::out_item_t  out_item;
  gsp_pkg::out_item_t  res;
  logic                res_valid;
  gsp_pkg::num_ctrl_t  num_ctrl;
  gsp_pkg::num_stat_t  num_stat;

  assign step        = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte <= in_ch.data_byte;
      s1_sof  <= in_ch.start_of_file;
    end
  end

  gsp_num u_num (
    .clk  (clk),
    .rst  (rst),
    .ctrl (num_ctrl),
    .stat (num_stat)
  );

  gsp_fsm u_fsm (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .data_byte     (s1_byte),
    .start_of_file (s1_sof),
    .num_stat      (num_stat),
    .num_ctrl      (num_ctrl),
    .res_valid     (res_valid),
    .res           (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ch.ready) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_item <= res;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.result_kind     = out_item.result_kind;
  assign out_ch.image_width     = out_item.image_width;
  assign out_ch.image_height    = out_item.image_height;
  assign out_ch.max_value       = out_item.max_value;
  assign out_ch.two_byte_pixels = out_item.two_byte_pixels;
  assign out_ch.pixel_value     = out_item.pixel_value;
  assign out_ch.last_pixel      = out_item.last_pixel;
  assign out_ch.error_code      = out_item.error_code;

endmodule

### rtl/core/gsp_checker.sv
module gsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_kind,
  input logic [15:0] image_width,
  input logic [15:0] image_height,
  input logic [16:0] max_value,
  input logic        two_byte_pixels,
  input logic [15:0] pixel_value,
  input logic        last_pixel,
  input logic [2:0]  error_code
);

  // a stalled result stays valid and keeps its kind, pixel value, error code and max value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
      $stable(pixel_value) && $stable(error_code) && $stable(max_value))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result_kind == gsp_pkg::KIND_HEADER) ||
      (result_kind == gsp_pkg::KIND_PIXEL) || (result_kind == gsp_pkg::KIND_ERROR))
    else $error("undefined result kind");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == gsp_pkg::KIND_PIXEL) |-> (image_width == 16'd0) &&
      (image_height == 16'd0) && (max_value == 17'd0) && (error_code == 3'd0) &&
      !two_byte_pixels)
    else $error("pixel result carries header or error fields");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == gsp_pkg::KIND_ERROR) |-> (error_code <= gsp_pkg::ERR_DIMENSION)
      && (pixel_value == 16'd0) && !last_pixel && (max_value == 17'd0))
    else $error("malformed error result");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == gsp_pkg::KIND_HEADER) |-> (max_value != 17'd0) &&
      (max_value <= 17'd65536) && (two_byte_pixels == (max_value > 17'd255)) &&
      (pixel_value == 16'd0) && !last_pixel)
    else $error("malformed header result");

endmodule

bind graymap_stream_parser_top gsp_checker u_gsp_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .result_kind     (out_ch.result_kind),
  .image_width     (out_ch.image_width),
  .image_height    (out_ch.image_height),
  .max_value       (out_ch.max_value),
  .two_byte_pixels (out_ch.two_byte_pixels),
  .pixel_value     (out_ch.pixel_value),
  .last_pixel      (out_ch.last_pixel),
  .error_code      (out_ch.error_code)
);
